// ===== hdl/pfdm_pkg.sv =====
// pfdm_pkg: shared types, constants and sample conversion functions
// for the pcm frame downmix block; no dependencies
package pfdm_pkg;

  // converted sample width, signed, 23 fraction bits
  localparam int unsigned SAMPLE_W = 25;
  localparam int unsigned CFG_DATA_W = 4;
  localparam int unsigned CFG_INDEX_W = 2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  localparam sample_t ONE_Q23 = 25'sd8388608;
  localparam logic [7:0] EXP_MAX = 8'hFF;
  localparam logic [7:0] EXP_BIAS = 8'd127;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SAMPLE_FORMAT    = 2'd0,
    REG_BYTES_PER_SAMPLE = 2'd1,
    REG_CHANNEL_COUNT    = 2'd2
  } reg_index_e;

  // sample format codes
  localparam logic FMT_PCM   = 1'b0;
  localparam logic FMT_FLOAT = 1'b1;

  typedef struct packed {
    logic       sample_format;
    logic [2:0] bytes_per_sample;
    logic [3:0] channel_count;
  } cfg_t;

  // status travelling with each queued word
  typedef struct packed {
    logic frame_done;
    logic end_clip;
    logic unsup;
  } flags_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_e;

  // integer pcm to q23, len is 1..4 bytes
  function automatic sample_t conv_pcm(logic [31:0] w, logic [2:0] len);
    sample_t s;
    case (len)
      3'd1:    s = {~w[7], ~w[7], w[6:0], 16'h0000};
      3'd2:    s = {{2{w[15]}}, w[15:0], 7'h00};
      3'd3:    s = {w[23], w[23:0]};
      default: s = {w[31], w[31:8]};
    endcase
    return s;
  endfunction

  // ieee single to q23, truncated toward zero, saturated to +-1.0, nan to zero
  function automatic sample_t conv_float(logic [31:0] w);
    logic [7:0]  expo;
    logic [22:0] mant;
    logic [23:0] full;
    logic [7:0]  sh;
    sample_t     mag;
    expo = w[30:23];
    mant = w[22:0];
    full = {1'b1, mant};
    sh   = EXP_BIAS - expo;
    if (expo == EXP_MAX) begin
      mag = (mant != 23'd0) ? '0 : ONE_Q23;
    end else if (expo >= EXP_BIAS) begin
      mag = ONE_Q23;
    end else if (expo == 8'd0) begin
      mag = '0;
    end else if (sh >= 8'd24) begin
      mag = '0;
    end else begin
      mag = {1'b0, full >> sh[4:0]};
    end
    // nan already has zero magnitude, so the sign can be applied throughout
    if (w[31]) begin
      return -mag;
    end
    return mag;
  endfunction

endpackage

// ===== hdl/pfdm_front.sv =====
// pfdm_front: takes data bytes, gathers samples, converts and sums a frame
// depends on pfdm_pkg
module pfdm_front #(
  parameter int unsigned MAX_CHANNELS = 8,
  parameter int unsigned SUM_W        = 29,
  parameter int unsigned DIV_W        = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pfdm_pkg::cfg_t      cfg_i,
  input  logic                accept_i,
  input  logic [7:0]          data_byte_i,
  input  logic                last_byte_i,
  output logic                q_push_o,
  output logic [SUM_W-1:0]    q_sum_o,
  output logic [DIV_W-1:0]    q_chans_o,
  output pfdm_pkg::flags_t    q_flags_o
);
  import pfdm_pkg::*;

  localparam int unsigned CP_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [31:0]       gather_q, gather_d;
  logic [1:0]        byte_pos_q, byte_pos_d;
  logic [CP_W-1:0]   chan_pos_q, chan_pos_d;
  logic [SUM_W-1:0]  sum_q, sum_d;

  logic [2:0]        len;
  logic [DIV_W-1:0]  chans;
  logic              unsup;
  logic [31:0]       word;
  logic              sample_end;
  logic              frame_end;
  sample_t           sample;
  logic [SUM_W-1:0]  sum_new;

  // effective sample length and channel count
  always_comb begin
    if (cfg_i.bytes_per_sample == 3'd0) begin
      len = 3'd1;
    end else if (cfg_i.bytes_per_sample > 3'd4) begin
      len = 3'd4;
    end else begin
      len = cfg_i.bytes_per_sample;
    end
    if (cfg_i.channel_count == 4'd0) begin
      chans = DIV_W'(1);
    end else if (int'(cfg_i.channel_count) > int'(MAX_CHANNELS)) begin
      chans = DIV_W'(MAX_CHANNELS);
    end else begin
      chans = DIV_W'(cfg_i.channel_count);
    end
    unsup = (cfg_i.bytes_per_sample == 3'd0) || (cfg_i.bytes_per_sample > 3'd4) ||
            (cfg_i.sample_format == FMT_FLOAT && cfg_i.bytes_per_sample != 3'd4);
  end

  // byte gather, conversion and running frame sum
  always_comb begin
    word       = gather_q | (32'(data_byte_i) << {byte_pos_q, 3'b000});
    sample_end = ({1'b0, byte_pos_q} + 3'd1) >= len;
    frame_end  = sample_end && ((int'(chan_pos_q) + 1) >= int'(chans));
    if (unsup) begin
      sample = '0;
    end else if (cfg_i.sample_format == FMT_FLOAT) begin
      sample = conv_float(word);
    end else begin
      sample = conv_pcm(word, len);
    end
    sum_new = sum_q + {{(SUM_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
  end

  // next stream state
  always_comb begin
    gather_d   = gather_q;
    byte_pos_d = byte_pos_q;
    chan_pos_d = chan_pos_q;
    sum_d      = sum_q;
    if (accept_i) begin
      if (sample_end) begin
        gather_d   = '0;
        byte_pos_d = '0;
        if (frame_end) begin
          chan_pos_d = '0;
          sum_d      = '0;
        end else begin
          chan_pos_d = chan_pos_q + CP_W'(1);
          sum_d      = sum_new;
        end
      end else begin
        gather_d   = word;
        byte_pos_d = byte_pos_q + 2'd1;
      end
      if (last_byte_i) begin
        gather_d   = '0;
        byte_pos_d = '0;
        chan_pos_d = '0;
        sum_d      = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gather_q   <= '0;
      byte_pos_q <= '0;
      chan_pos_q <= '0;
      sum_q      <= '0;
    end else begin
      gather_q   <= gather_d;
      byte_pos_q <= byte_pos_d;
      chan_pos_q <= chan_pos_d;
      sum_q      <= sum_d;
    end
  end

  // word towards the back end
  assign q_push_o             = accept_i && (frame_end || last_byte_i);
  assign q_sum_o              = sum_new;
  assign q_chans_o            = chans;
  assign q_flags_o.frame_done = frame_end;
  assign q_flags_o.end_clip   = last_byte_i;
  assign q_flags_o.unsup      = unsup;

endmodule

// ===== hdl/pfdm_fifo.sv =====
// pfdm_fifo: short register queue between front and back end
// no dependencies
module pfdm_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];

  // pointer and fill count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> cnt_q != CNT_W'(DEPTH))
    else $error("queue written while full");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("queue read while empty");

endmodule

// ===== hdl/pfdm_back.sv =====
// pfdm_back: divides each frame sum by the channel count and holds the result word
// depends on pfdm_pkg
module pfdm_back #(
  parameter int unsigned SUM_W = 29,
  parameter int unsigned DIV_W = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_empty_i,
  input  logic [SUM_W-1:0]      q_sum_i,
  input  logic [DIV_W-1:0]      q_chans_i,
  input  pfdm_pkg::flags_t      q_flags_i,
  output logic                  q_pop_o,
  input  logic                  pop_i,
  output logic                  out_vld_o,
  output pfdm_pkg::sample_t     out_sample_o,
  output pfdm_pkg::flags_t      out_flags_o
);
  import pfdm_pkg::*;

  localparam int unsigned CNT_W = $clog2(SUM_W + 1);

  back_state_e      state_q, state_d;
  logic [SUM_W-1:0] quot_q, quot_d;
  logic [DIV_W:0]   rem_q, rem_d;
  logic [DIV_W-1:0] div_q, div_d;
  logic             neg_q, neg_d;
  flags_t           flags_q, flags_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic             out_vld_q, out_vld_d;
  sample_t          out_sample_q;
  flags_t           out_flags_q;

  logic             slot_free;
  logic             out_load;
  logic             need_div;
  logic [DIV_W:0]   rem_sh;
  logic             ge;
  logic [SUM_W-1:0] res_full;

  assign slot_free = !out_vld_q || pop_i;
  assign need_div  = q_flags_i.frame_done && (q_chans_i != DIV_W'(1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          state_d = need_div ? BK_DIV : BK_DONE;
        end
      end
      BK_DIV: begin
        if (cnt_q == CNT_W'(1)) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (slot_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    q_pop_o  = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      BK_IDLE: q_pop_o  = !q_empty_i;
      BK_DONE: out_load = slot_free;
      default: begin
        q_pop_o  = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  // one restoring divide step
  always_comb begin
    rem_sh   = {rem_q[DIV_W-1:0], quot_q[SUM_W-1]};
    ge       = rem_sh >= {1'b0, div_q};
    res_full = neg_q ? -quot_q : quot_q;
  end

  // divider datapath
  always_comb begin
    quot_d  = quot_q;
    rem_d   = rem_q;
    div_d   = div_q;
    neg_d   = neg_q;
    flags_d = flags_q;
    cnt_d   = cnt_q;
    if (q_pop_o) begin
      flags_d = q_flags_i;
      div_d   = q_chans_i;
      rem_d   = '0;
      cnt_d   = CNT_W'(SUM_W);
      if (need_div) begin
        neg_d  = q_sum_i[SUM_W-1];
        quot_d = q_sum_i[SUM_W-1] ? -q_sum_i : q_sum_i;
      end else begin
        neg_d  = 1'b0;
        quot_d = q_flags_i.frame_done ? q_sum_i : '0;
      end
    end else if (state_q == BK_DIV) begin
      rem_d  = ge ? (rem_sh - {1'b0, div_q}) : rem_sh;
      quot_d = {quot_q[SUM_W-2:0], ge};
      cnt_d  = cnt_q - CNT_W'(1);
    end
  end

  // result word register
  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (pop_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q  <= quot_d;
    rem_q   <= rem_d;
    div_q   <= div_d;
    neg_q   <= neg_d;
    flags_q <= flags_d;
    if (out_load) begin
      out_sample_q <= res_full[SAMPLE_W-1:0];
      out_flags_q  <= flags_q;
    end
  end

  assign out_vld_o    = out_vld_q;
  assign out_sample_o = out_sample_q;
  assign out_flags_o  = out_flags_q;

  a_div_count_live : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_DIV |-> cnt_q != '0)
    else $error("divider running with exhausted step count");

  a_rem_below_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_DIV |-> rem_q < {1'b0, div_q})
    else $error("partial remainder not below divisor");

endmodule

// ===== hdl/pcm_frame_downmix_to_mono.sv =====
// Byte-wide WAV sample decoder with mono downmix. Data bytes enter one per
// cycle through push/full; each result word leaves through empty/pop. The
// front end takes a byte every cycle while the result queue has room. The
// back end loads a word that needs no division (one channel, or an
// end-of-clip word without a frame) straight into its result register, and
// runs a frame of two or more channels through its bit-serial restoring
// divider first; it takes no new word until the result register has taken the
// last. A four-word queue between the two absorbs bursts. The configuration
// port is always ready; registers should be written only while no word is in
// flight.
module pcm_frame_downmix_to_mono #(
  parameter int unsigned MAX_CHANNELS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pfdm_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [pfdm_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // byte input
  input  logic                                push,
  output logic                                full,
  input  logic [7:0]                          data_byte_i,
  input  logic                                last_byte_i,
  // result output
  output logic                                empty,
  input  logic                                pop,
  output logic signed [pfdm_pkg::SAMPLE_W-1:0] mono_sample_o,
  output logic                                sample_valid_o,
  output logic                                end_of_clip_o,
  output logic                                unsupported_format_o
);
  import pfdm_pkg::*;

  localparam int unsigned SUM_W   = SAMPLE_W + 1 + $clog2(MAX_CHANNELS);
  localparam int unsigned DIV_W   = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned FLAGS_W = $bits(flags_t);
  localparam int unsigned ENTRY_W = SUM_W + DIV_W + FLAGS_W;
  localparam int unsigned Q_DEPTH = 4;

  cfg_t             cfg_q, cfg_d;
  logic             accept;
  logic             q_push, q_pop, q_full, q_empty;
  logic [SUM_W-1:0] f_sum, b_sum;
  logic [DIV_W-1:0] f_chans, b_chans;
  flags_t           f_flags, b_flags, out_flags;
  logic [ENTRY_W-1:0] q_wdata, q_rdata;
  logic             out_vld;
  sample_t          out_sample;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (reg_index_e'(cfg_index_i))
        REG_SAMPLE_FORMAT:    cfg_d.sample_format    = cfg_data_i[0];
        REG_BYTES_PER_SAMPLE: cfg_d.bytes_per_sample = cfg_data_i[2:0];
        REG_CHANNEL_COUNT:    cfg_d.channel_count    = cfg_data_i[3:0];
        default:              cfg_d                  = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_format    <= FMT_PCM;
      cfg_q.bytes_per_sample <= 3'd2;
      cfg_q.channel_count    <= 4'd1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // input handshake
  assign full   = q_full;
  assign accept = push && !q_full;

  pfdm_front #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .SUM_W        (SUM_W),
    .DIV_W        (DIV_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .q_push_o    (q_push),
    .q_sum_o     (f_sum),
    .q_chans_o   (f_chans),
    .q_flags_o   (f_flags)
  );

  // queue between front and back end
  assign q_wdata = {f_sum, f_chans, f_flags};

  pfdm_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (Q_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  assign b_sum   = q_rdata[ENTRY_W-1 -: SUM_W];
  assign b_chans = q_rdata[FLAGS_W +: DIV_W];
  assign b_flags = q_rdata[FLAGS_W-1:0];

  pfdm_back #(
    .SUM_W (SUM_W),
    .DIV_W (DIV_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_sum_i      (b_sum),
    .q_chans_i    (b_chans),
    .q_flags_i    (b_flags),
    .q_pop_o      (q_pop),
    .pop_i        (pop && out_vld),
    .out_vld_o    (out_vld),
    .out_sample_o (out_sample),
    .out_flags_o  (out_flags)
  );

  // result ports
  assign empty                = !out_vld;
  assign mono_sample_o        = out_sample;
  assign sample_valid_o       = out_flags.frame_done;
  assign end_of_clip_o        = out_flags.end_clip;
  assign unsupported_format_o = out_flags.unsup;

  a_idle_word_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !sample_valid_o |-> mono_sample_o == '0)
    else $error("word without a frame carries a nonzero sample");

endmodule

// ===== verif/tb_pcm_frame_downmix_to_mono.sv =====
// tb_pcm_frame_downmix_to_mono: self-checking bench for the wav byte decoder with mono
// downmix; a scoreboard class predicts each result word from the accepted bytes
// depends on pfdm_pkg and pcm_frame_downmix_to_mono
module tb_pcm_frame_downmix_to_mono;
  import pfdm_pkg::*;

  localparam int unsigned MAX_CHANNELS = 8;
  localparam int unsigned RANDOM_BYTES = 1200;
  localparam int unsigned SETTLE_CYCLES = 40;

  // one expected result word
  typedef struct {
    sample_t mono;
    logic    valid;
    logic    eoc;
    logic    unsup;
  } mono_word_t;

  // predicts the mixed words from the byte stream and checks them in order
  class downmix_scoreboard;
    logic             fmt_r;
    logic [2:0]       bps_r;
    logic [3:0]       chan_r;
    logic [31:0]      gather;
    int unsigned      byte_pos;
    int unsigned      chan_pos;
    longint           chan_acc;
    mono_word_t       mono_words_q[$];
    int unsigned      errors;

    function new();
      fmt_r    = FMT_PCM;
      bps_r    = 3'd2;
      chan_r   = 4'd1;
      gather   = '0;
      byte_pos = 0;
      chan_pos = 0;
      chan_acc = 0;
      errors   = 0;
    endfunction

    function void write_reg(reg_index_e idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_SAMPLE_FORMAT:    fmt_r = val[0];
        REG_BYTES_PER_SAMPLE: bps_r = val[2:0];
        REG_CHANNEL_COUNT:    chan_r = val[3:0];
        default: ;
      endcase
    endfunction

    // ieee single to q23: truncate toward zero, saturate at one, nan gives zero
    function int float_to_q23(logic [31:0] w);
      int unsigned e;
      int          mag;
      e = w[30:23];
      if (e == 255 && w[22:0] != 23'd0) return 0;
      if (e >= 127) mag = 1 << 23;
      else if (e == 0) mag = 0;
      else if (127 - e >= 24) mag = 0;
      else mag = int'({1'b1, w[22:0]} >> (127 - e));
      return w[31] ? -mag : mag;
    endfunction

    // integer pcm of len bytes to q23
    function int pcm_to_q23(logic [31:0] w, int unsigned len);
      case (len)
        1:       return (int'(w[7:0]) - 128) * 65536;
        2:       return int'($signed(w[15:0])) * 128;
        3:       return int'($signed(w[23:0]));
        default: return $signed(w) >>> 8;
      endcase
    endfunction

    // fold one accepted byte into the frame; queue a word when one is due
    function void take_byte(logic [7:0] b, logic lst);
      int unsigned len;
      int unsigned chans;
      logic        unsup;
      logic        done;
      int          conv;
      longint      mixed;
      mono_word_t  w;
      unsup = (bps_r < 3'd1 || bps_r > 3'd4) || (fmt_r == FMT_FLOAT && bps_r != 3'd4);
      len   = (bps_r == 3'd0) ? 1 : (bps_r > 3'd4) ? 4 : bps_r;
      chans = (chan_r == 4'd0) ? 1 : (chan_r > MAX_CHANNELS) ? MAX_CHANNELS : chan_r;
      done  = 1'b0;
      mixed = 0;
      gather |= 32'(b) << (8 * (byte_pos & 3));
      if (byte_pos + 1 >= len) begin
        conv = 0;
        if (!unsup) conv = (fmt_r == FMT_FLOAT) ? float_to_q23(gather) : pcm_to_q23(gather, len);
        chan_acc += conv;
        gather   = '0;
        byte_pos = 0;
        if (chan_pos + 1 >= chans) begin
          mixed    = chan_acc / longint'(chans);
          done     = 1'b1;
          chan_pos = 0;
          chan_acc = 0;
        end else begin
          chan_pos++;
        end
      end else begin
        byte_pos++;
      end
      // end of clip drops whatever partial frame is left
      if (lst) begin
        gather   = '0;
        byte_pos = 0;
        chan_pos = 0;
        chan_acc = 0;
      end
      if (done || lst) begin
        w.mono  = done ? sample_t'(mixed) : '0;
        w.valid = done;
        w.eoc   = lst;
        w.unsup = unsup;
        mono_words_q.insert(mono_words_q.size(), w);
      end
    endfunction

    function void report(string field, longint want, longint got);
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
      errors++;
    endfunction

    function void check_mono_word(sample_t mono, logic valid, logic eoc, logic unsup);
      mono_word_t want;
      if (mono_words_q.size() == 0) begin
        $display("%0t: unexpected word, expected none actual mono_sample %0d", $time, mono);
        errors++;
        return;
      end
      want = mono_words_q.pop_front();
      if (mono !== want.mono) report("mono_sample", want.mono, mono);
      if (valid !== want.valid) report("sample_valid", want.valid, valid);
      if (eoc !== want.eoc) report("end_of_clip", want.eoc, eoc);
      if (unsup !== want.unsup) report("unsupported_format", want.unsup, unsup);
    endfunction

    function int unsigned pending();
      return mono_words_q.size();
    endfunction

    function int unsigned failures();
      return errors + mono_words_q.size();
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;
  logic                   push;
  logic                   full;
  logic [7:0]             data_byte_i;
  logic                   last_byte_i;
  logic                   empty;
  logic                   pop = 1'b0;
  sample_t                mono_sample_o;
  logic                   sample_valid_o;
  logic                   end_of_clip_o;
  logic                   unsupported_format_o;

  downmix_scoreboard mix_sb;
  int unsigned       burst_left;
  int unsigned       rand_sent;
  int unsigned       pop_mode;
  int unsigned       pop_left;
  int unsigned       cur_fmt;
  int unsigned       cur_len;
  int unsigned       cur_chans;

  pcm_frame_downmix_to_mono #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .push                (push),
    .full                (full),
    .data_byte_i         (data_byte_i),
    .last_byte_i         (last_byte_i),
    .empty               (empty),
    .pop                 (pop),
    .mono_sample_o       (mono_sample_o),
    .sample_valid_o      (sample_valid_o),
    .end_of_clip_o       (end_of_clip_o),
    .unsupported_format_o(unsupported_format_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("tb_pcm_frame_downmix_to_mono: errors");
    $finish;
  end

  // receiver: check each popped word, stall on a changing pattern
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      mix_sb.check_mono_word(mono_sample_o, sample_valid_o, end_of_clip_o, unsupported_format_o);
    end
    if (pop_left == 0) begin
      pop_mode = $urandom_range(0, 3);
      pop_left = (pop_mode == 3) ? $urandom_range(5, 30) : $urandom_range(5, 60);
    end
    pop_left--;
    case (pop_mode)
      0:       pop <= 1'b1;
      1:       pop <= 1'($urandom_range(0, 1));
      2:       pop <= ($urandom_range(0, 3) == 0);
      default: pop <= 1'b0;
    endcase
  end

  // sender pacing: bursts of bytes with random gaps, some with none
  task automatic pace();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      case ($urandom_range(0, 5))
        0, 1:    gap = 0;
        2:       gap = $urandom_range(10, 30);
        default: gap = $urandom_range(1, 4);
      endcase
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic lst);
    pace();
    push        <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= lst;
    do @(posedge clk_i); while (full);
    mix_sb.take_byte(b, lst);
  endtask

  // one sample of the current size, low byte first
  task automatic send_sample(input logic [31:0] w, input logic lst);
    for (int k = 0; k < cur_len; k++) begin
      send_byte(w[8*k +: 8], lst && (k == cur_len - 1));
    end
  endtask

  // wait until every expected word has come out, then let the back end settle
  task automatic drain_words();
    push <= 1'b0;
    while (mix_sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_index_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    mix_sb.write_reg(idx, val);
  endtask

  task automatic set_cfg(input int unsigned fmt, input int unsigned bps, input int unsigned ch);
    write_reg(REG_SAMPLE_FORMAT, CFG_DATA_W'(fmt));
    write_reg(REG_BYTES_PER_SAMPLE, CFG_DATA_W'(bps));
    write_reg(REG_CHANNEL_COUNT, CFG_DATA_W'(ch));
    cfg_valid_i <= 1'b0;
    cur_fmt   = fmt;
    cur_len   = (bps == 0) ? 1 : (bps > 4) ? 4 : bps;
    cur_chans = (ch == 0) ? 1 : (ch > MAX_CHANNELS) ? MAX_CHANNELS : ch;
  endtask

  // float words biased toward zero, saturation, nan and the small-value cut-off
  function automatic logic [31:0] float_word();
    logic [7:0]  e;
    logic [22:0] m;
    m = ($urandom_range(0, 7) == 0) ? 23'd0 : 23'($urandom);
    case ($urandom_range(0, 7))
      0:       e = 8'd0;
      1:       e = 8'hFF;
      2:       e = 8'($urandom_range(127, 254));
      3:       e = 8'd126;
      4:       e = 8'($urandom_range(1, 103));
      default: e = 8'($urandom_range(104, 126));
    endcase
    return {1'($urandom), e, m};
  endfunction

  // pcm words with the extremes of the current size mixed in
  function automatic logic [31:0] pcm_word(int unsigned len);
    logic [31:0] top;
    top = 32'h1 << (8 * len - 1);
    case ($urandom_range(0, 7))
      0:       return 32'h0;
      1:       return '1;
      2:       return top;
      3:       return top - 1;
      default: return $urandom;
    endcase
  endfunction

  // one random setting, a run of frames, then the clip closed on a frame boundary, inside a partial frame or left open
  task automatic random_phase();
    int unsigned kind;
    int unsigned fmt;
    int unsigned bps;
    int unsigned ch;
    int unsigned r;
    int unsigned frames;
    int unsigned tail;
    int unsigned n;
    logic [31:0] w;
    logic        lst;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: begin
        fmt = FMT_PCM;
        bps = $urandom_range(1, 4);
      end
      4, 5, 6: begin
        fmt = FMT_FLOAT;
        bps = 4;
      end
      7: begin
        fmt = FMT_FLOAT;
        bps = $urandom_range(0, 6);
        if (bps >= 4) bps++;
      end
      8: begin
        fmt = FMT_PCM;
        r   = $urandom_range(0, 3);
        bps = (r == 0) ? 0 : r + 4;
      end
      default: begin
        fmt = $urandom_range(0, 1);
        bps = $urandom_range(0, 7);
      end
    endcase
    case ($urandom_range(0, 9))
      0: ch = 1;
      1: ch = MAX_CHANNELS;
      2: begin
        r  = $urandom_range(0, 7);
        ch = (r == 0) ? 0 : r + 8;
      end
      default: ch = $urandom_range(1, MAX_CHANNELS);
    endcase
    set_cfg(fmt, bps, ch);
    frames = $urandom_range(1, 12);
    // 0,1 close on a frame boundary, 2 close inside a partial frame, 3 leave open
    tail = $urandom_range(0, 3);
    for (int f = 0; f < frames; f++) begin
      for (int c = 0; c < cur_chans; c++) begin
        w = (cur_fmt == FMT_FLOAT) ? float_word() : pcm_word(cur_len);
        for (int k = 0; k < cur_len; k++) begin
          lst = ($urandom_range(0, 59) == 0) ||
                (tail < 2 && f == frames - 1 && c == cur_chans - 1 && k == cur_len - 1);
          send_byte(w[8*k +: 8], lst);
          rand_sent++;
        end
      end
    end
    if (tail == 2) begin
      n = $urandom_range(1, 3);
      for (int k = 0; k < n; k++) begin
        send_byte(8'($urandom), k == n - 1);
        rand_sent++;
      end
    end
    drain_words();
  endtask

  // main sequence
  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_SAMPLE_FORMAT;
    cfg_data_i  = '0;
    push        = 1'b0;
    data_byte_i = '0;
    last_byte_i = 1'b0;
    burst_left  = 0;
    rand_sent   = 0;
    pop_mode    = 0;
    pop_left    = 0;
    cur_fmt     = FMT_PCM;
    cur_len     = 2;
    cur_chans   = 1;
    mix_sb      = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset setting, 16-bit mono: extremes, then a lone byte closing the clip
    send_sample(32'h0000_8000, 1'b0);
    send_sample(32'h0000_7FFF, 1'b0);
    send_byte(8'h01, 1'b1);
    drain_words();

    // 8-bit stereo: offset binary extremes, frame ending with the clip
    set_cfg(FMT_PCM, 1, 2);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b1);
    drain_words();

    // float: one, negative infinity, nan
    set_cfg(FMT_FLOAT, 4, 1);
    send_sample(32'h3F80_0000, 1'b0);
    send_sample(32'hFF80_0000, 1'b0);
    send_sample(32'h7FC0_0000, 1'b0);
    drain_words();

    // float with a short sample is flagged and mixes to zero
    set_cfg(FMT_FLOAT, 2, 1);
    send_sample(32'h0000_7FFF, 1'b0);
    drain_words();

    // zero sizes act as one byte and one channel, still flagged
    set_cfg(FMT_PCM, 0, 0);
    send_byte(8'hFF, 1'b1);
    drain_words();

    // 24-bit minimum
    set_cfg(FMT_PCM, 3, 1);
    send_sample(32'h0080_0000, 1'b1);
    drain_words();

    while (rand_sent < RANDOM_BYTES) random_phase();

    if (mix_sb.failures() == 0) begin
      $display("tb_pcm_frame_downmix_to_mono: clean");
    end else begin
      $display("tb_pcm_frame_downmix_to_mono: errors");
    end
    $finish;
  end

endmodule
